@@ src/tbcf_pkg.sv @@
// tbcf_pkg: shared types, constants and helper functions for the raster framer
// used by tbcf_front, tbcf_cmd_fifo, tbcf_back and thermal_bitmap_chunk_framer
`timescale 1ns / 1ps

package tbcf_pkg;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_W    = 14;
    localparam int HEIGHT_W   = 16;

    // row clipping and width clamp
    localparam logic [10:0]        MAX_ROW_BYTES = 11'd48;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_PIX = 14'd8192;

    // framing bytes
    localparam logic [7:0] HDR_DC2   = 8'h12;
    localparam logic [7:0] HDR_STAR  = 8'h2A;
    localparam logic [7:0] FORM_FEED = 8'h0C;

    // one classified input word, handed from front to back
    typedef struct packed {
        logic       hdr;
        logic [7:0] rows;
        logic [5:0] clip;
        logic       data;
        logic [7:0] data_byte;
        logic       ff;
    } tbcf_cmd_t;

    // rows per chunk: 256 buffer bytes over the clipped row length, held to 1..255
    function automatic logic [7:0] chunk_limit_lut(input logic [5:0] clip);
        logic [7:0] lim;
        unique case (clip)
            6'd1:  lim = 8'd255;
            6'd2:  lim = 8'd128;
            6'd3:  lim = 8'd85;
            6'd4:  lim = 8'd64;
            6'd5:  lim = 8'd51;
            6'd6:  lim = 8'd42;
            6'd7:  lim = 8'd36;
            6'd8:  lim = 8'd32;
            6'd9:  lim = 8'd28;
            6'd10: lim = 8'd25;
            6'd11: lim = 8'd23;
            6'd12: lim = 8'd21;
            6'd13: lim = 8'd19;
            6'd14: lim = 8'd18;
            6'd15: lim = 8'd17;
            6'd16: lim = 8'd16;
            6'd17: lim = 8'd15;
            6'd18: lim = 8'd14;
            6'd19: lim = 8'd13;
            6'd20, 6'd21: lim = 8'd12;
            6'd22, 6'd23: lim = 8'd11;
            6'd24, 6'd25: lim = 8'd10;
            6'd26, 6'd27, 6'd28: lim = 8'd9;
            6'd29, 6'd30, 6'd31, 6'd32: lim = 8'd8;
            6'd33, 6'd34, 6'd35, 6'd36: lim = 8'd7;
            6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42: lim = 8'd6;
            6'd43, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48: lim = 8'd5;
            default: lim = 8'd1;
        endcase
        return lim;
    endfunction

    // bit-reverse then invert a pixel byte
    function automatic logic [7:0] flip_invert(input logic [7:0] b);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[7-k] = b[k];
        end
        return ~r;
    endfunction

endpackage

@@ src/tbcf_front.sv @@
// tbcf_front: configuration registers, row/chunk counters and word classification
// depends on tbcf_pkg; feeds tbcf_cmd_fifo
`timescale 1ns / 1ps

module tbcf_front
    import tbcf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] pixel_byte
    input  logic                  q_full,
    output logic                  q_push,
    output tbcf_cmd_t             q_push_cmd
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [9:0]          col_reg, col_next;
    logic [15:0]         row_reg, row_next;
    logic [7:0]          ric_reg, ric_next;
    logic [7:0]          limit_reg, limit_next;

    logic [WIDTH_W-1:0] w_clamp;
    logic [WIDTH_W-1:0] w_plus;
    logic [10:0]        row_bytes;
    logic [5:0]         clip;
    logic [15:0]        h;
    logic               start;
    logic [7:0]         lim;
    logic [15:0]        left;
    logic [7:0]         rows;
    logic [10:0]        col_plus;
    logic [16:0]        row_plus;
    logic [7:0]         ric_plus;
    logic               row_end, img_end, accept;
    tbcf_cmd_t          cmd;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // row geometry from the registers
    always_comb begin
        if (width_reg == '0) begin
            w_clamp = 14'd1;
        end else if (width_reg > MAX_WIDTH_PIX) begin
            w_clamp = MAX_WIDTH_PIX;
        end else begin
            w_clamp = width_reg;
        end
        w_plus    = w_clamp + 14'd7;
        row_bytes = w_plus[13:3];
        clip      = (row_bytes >= MAX_ROW_BYTES) ? MAX_ROW_BYTES[5:0] : row_bytes[5:0];
        h         = (height_reg == '0) ? 16'd1 : height_reg;
    end

    // chunk header contents and end of row / image
    always_comb begin
        start    = (row_reg == '0) && (col_reg == '0);
        lim      = start ? chunk_limit_lut(clip) : limit_reg;
        left     = (h > row_reg) ? (h - row_reg) : 16'd1;
        rows     = (left > {8'd0, lim}) ? lim : left[7:0];
        if (rows == '0) begin
            rows = 8'd1;
        end
        col_plus = {1'b0, col_reg} + 11'd1;
        row_plus = {1'b0, row_reg} + 17'd1;
        ric_plus = ric_reg + 8'd1;
        row_end  = col_plus >= row_bytes;
        img_end  = row_plus >= {1'b0, h};

        cmd.hdr       = (col_reg == '0) && (ric_reg == '0);
        cmd.rows      = rows;
        cmd.clip      = clip;
        cmd.data      = col_reg < {4'd0, clip};
        cmd.data_byte = flip_invert(s_tdata);
        cmd.ff        = row_end && img_end;
    end

    // counter update for an accepted word
    always_comb begin
        col_next   = col_reg;
        row_next   = row_reg;
        ric_next   = ric_reg;
        limit_next = limit_reg;
        if (accept) begin
            limit_next = lim;
            if (row_end) begin
                col_next = '0;
                if (img_end) begin
                    row_next = '0;
                    ric_next = '0;
                end else begin
                    row_next = row_plus[15:0];
                    ric_next = (ric_plus >= lim) ? 8'd0 : ric_plus;
                end
            end else begin
                col_next = col_plus[9:0];
            end
        end
    end

    // words that make no output byte are not queued
    assign q_push     = accept && (cmd.hdr || cmd.data || cmd.ff);
    assign q_push_cmd = cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 14'd384;
            height_reg <= 16'd1;
            col_reg    <= '0;
            row_reg    <= '0;
            ric_reg    <= '0;
            limit_reg  <= '0;
        end else begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            ric_reg   <= ric_next;
            limit_reg <= limit_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_IMAGE_WIDTH:  width_reg  <= cfg_wr_data[WIDTH_W-1:0];
                    REG_IMAGE_HEIGHT: height_reg <= cfg_wr_data[HEIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ src/tbcf_cmd_fifo.sv @@
// tbcf_cmd_fifo: four-entry queue of classified words between front and back
// depends on tbcf_pkg
`timescale 1ns / 1ps

module tbcf_cmd_fifo
    import tbcf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  tbcf_cmd_t push_cmd,
    output logic      full,
    input  logic      pop,
    output tbcf_cmd_t head_cmd,
    output logic      empty
);

    tbcf_cmd_t  mem_reg [0:3];
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] count_reg;
    logic       do_push, do_pop;

    assign full     = (count_reg == 3'd4);
    assign empty    = (count_reg == 3'd0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 3'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 3'd1;
            end
        end
    end

endmodule

@@ src/tbcf_back.sv @@
// tbcf_back: expands a queued word into header, data and form feed bytes
// depends on tbcf_pkg; drives the output register of the result channel
`timescale 1ns / 1ps

module tbcf_back
    import tbcf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  tbcf_cmd_t  head_cmd,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic       m_tlast     // last_of_run
);

    // byte slots: four header bytes, data byte, form feed
    localparam int SLOT_ROWS = 2;
    localparam int SLOT_CLIP = 3;
    localparam int SLOT_DATA = 4;
    localparam int SLOT_FF   = 5;

    tbcf_cmd_t  cmd_reg;
    logic [5:0] mask_reg, mask_next;
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;

    logic       busy, can_emit, last;
    logic [5:0] pick, mask_after;
    logic [7:0] byte_out;

    assign busy     = (mask_reg != '0);
    assign can_emit = busy && (!m_tvalid_reg || m_tready);

    // lowest pending slot goes out first
    always_comb begin
        pick       = mask_reg & (~mask_reg + 6'd1);
        mask_after = mask_reg & ~pick;
        last       = (mask_after == '0);
        priority case (1'b1)
            pick[SLOT_FF]:   byte_out = FORM_FEED;
            pick[SLOT_DATA]: byte_out = cmd_reg.data_byte;
            pick[SLOT_CLIP]: byte_out = {2'b00, cmd_reg.clip};
            pick[SLOT_ROWS]: byte_out = cmd_reg.rows;
            pick[1]:         byte_out = HDR_STAR;
            default:         byte_out = HDR_DC2;
        endcase
    end

    // take the next word when idle or on the last byte of the current one
    assign q_pop = !q_empty && (!busy || (can_emit && last));

    always_comb begin
        mask_next = mask_reg;
        if (q_pop) begin
            mask_next = {head_cmd.ff, head_cmd.data, {4{head_cmd.hdr}}};
        end else if (can_emit) begin
            mask_next = mask_after;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= head_cmd;
        end
        if (can_emit) begin
            m_tdata_reg <= byte_out;
            m_tlast_reg <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            mask_reg <= mask_next;
            if (can_emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ src/thermal_bitmap_chunk_framer.sv @@
// thermal_bitmap_chunk_framer: top level of the raster framer for a thermal printer
// depends on tbcf_pkg, tbcf_front, tbcf_cmd_fifo, tbcf_back
//
// Usage:
//   s_ channel takes bitmap bytes in row-major order, one word per handshake.
//   m_ channel gives printer bytes: a four-byte chunk header (0x12, '*', rows,
//   clipped row bytes) before each chunk, the bit-reversed and inverted data
//   bytes of each row clipped to 48, and a form feed after the last image byte.
//   m_tlast marks the final byte caused by one input word.
//   cfg_wr_en / cfg_addr / cfg_wr_data write width (index 0) and height (index 1);
//   write only while the block is idle.
// Path: an accepted word is written into the queue, then taken into the back's
//   word register, and its bytes leave through the output register.
// Throughput: the front accepts one word per cycle while the four-word queue
//   has room; the back sends one byte per cycle while m_tready is high. A word
//   makes one byte as plain data, up to six at a chunk start; words past the
//   row clip make no bytes and are not queued, bar the form feed ending an image.
// Stall: when m_tready is low the output register holds, the queue fills and
//   s_tready drops once four words are waiting.
// Reset: aresetn (synchronous, active low) empties the queue, clears the row
//   and chunk counters and loads width 384, height 1.
`timescale 1ns / 1ps

module thermal_bitmap_chunk_framer
    import tbcf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] pixel_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [7:0] out_byte
    output logic                  m_tlast     // last_of_run
);

    logic      q_full, q_push, q_pop, q_empty;
    tbcf_cmd_t q_push_cmd, q_head_cmd;

    // classify incoming words
    tbcf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_cmd  (q_push_cmd)
    );

    // decoupling queue
    tbcf_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (q_head_cmd),
        .empty    (q_empty)
    );

    // byte sequencer and output register
    tbcf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (q_head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ test/thermal_bitmap_chunk_framer_tb.sv @@
// thermal_bitmap_chunk_framer_tb: self-checking bench for the raster framer, predicts every
// printer byte from the pixel words it sends and the widths and heights it writes
// depends on tbcf_pkg and thermal_bitmap_chunk_framer
`timescale 1ns / 1ps

module thermal_bitmap_chunk_framer_tb;
    import tbcf_pkg::*;

    localparam int RANDOM_ITEMS  = 250;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 10;

    // one printer byte as it should leave the m_ side
    typedef struct {
        logic [7:0] data;
        logic       last;
    } printer_byte_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_addr = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = 8'h00;    // [7:0] pixel_byte
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;            // [7:0] out_byte
    logic                  m_tlast;            // last_of_run

    // shadow of the framer state and its registers
    logic [WIDTH_W-1:0]  width_reg = 14'd384;
    logic [HEIGHT_W-1:0] height_reg = 16'd1;
    logic [9:0]          col_cnt = '0;
    logic [15:0]         row_cnt = '0;
    logic [7:0]          chunk_row = '0;
    logic [7:0]          chunk_lim = '0;

    printer_byte_t expected_bytes[$];

    int mismatches = 0;
    int pixel_words_in = 0;
    int printer_bytes_out = 0;
    int config_writes = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;

    thermal_bitmap_chunk_framer dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // bytes per row after the width clamp
    function automatic int unsigned row_len(input logic [WIDTH_W-1:0] w);
        int unsigned px;
        px = w;
        if (px < 1) px = 1;
        if (px > 8192) px = 8192;
        return (px + 7) / 8;
    endfunction

    // work out the printer bytes caused by one pixel word and advance the shadow state
    function automatic void frame_pixel(input logic [7:0] pix);
        int unsigned rb, clip, h, lim, left, rows;
        logic [7:0]  rev;
        logic [7:0]  burst[$];
        printer_byte_t pb;
        rb = row_len(width_reg);
        clip = (rb >= 48) ? 48 : rb;
        h = (height_reg == 0) ? 1 : height_reg;

        // rows per chunk latched on the first word of an image
        if (row_cnt == 0 && col_cnt == 0) begin
            lim = 256 / clip;
            if (lim > 255) lim = 255;
            if (lim < 1) lim = 1;
            chunk_lim = lim[7:0];
        end

        // chunk header
        if (col_cnt == 0 && chunk_row == 0) begin
            left = (h > row_cnt) ? h - row_cnt : 1;
            rows = (left > chunk_lim) ? chunk_lim : left;
            if (rows < 1) rows = 1;
            burst.push_back(HDR_DC2);
            burst.push_back(HDR_STAR);
            burst.push_back(rows[7:0]);
            burst.push_back(clip[7:0]);
        end

        // data byte, only inside the clipped part of the row
        if (col_cnt < clip) begin
            rev = {<<{pix}};
            burst.push_back(~rev);
        end

        // row and image bookkeeping
        if (col_cnt + 1 >= rb) begin
            col_cnt = '0;
            if (row_cnt + 1 >= h) begin
                burst.push_back(FORM_FEED);
                row_cnt = '0;
                chunk_row = '0;
            end else begin
                row_cnt = row_cnt + 16'd1;
                chunk_row = chunk_row + 8'd1;
                if (chunk_row >= chunk_lim) chunk_row = '0;
            end
        end else begin
            col_cnt = col_cnt + 10'd1;
        end

        foreach (burst[i]) begin
            pb.data = burst[i];
            pb.last = (i == burst.size() - 1);
            expected_bytes.push_back(pb);
        end
    endfunction

    // result side backpressure in random bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (stall_pct == 0 || $urandom_range(0, 99) >= stall_pct) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // compare each printer byte with the oldest prediction
    always @(posedge aclk) begin
        printer_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            printer_bytes_out++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected printer byte %02h last %0b with nothing pending",
                             m_tdata, m_tlast);
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data || m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                                 printer_bytes_out, want.data, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles, %0d bytes pending",
                         idle_cycles, expected_bytes.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // offer one pixel word, with an optional random gap first
    task automatic send_pixel(input logic [7:0] pix);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        pixel_words_in++;
        frame_pixel(pix);
    endtask

    // stop sending and let every pending byte drain, plus the pipeline depth
    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register write, always from an idle block
    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        config_writes++;
        if (idx == REG_IMAGE_WIDTH) width_reg = value[WIDTH_W-1:0];
        else height_reg = value[HEIGHT_W-1:0];
    endtask

    // two rows of five bytes with all-zero, all-one and walking patterns
    task automatic test_pixel_extremes();
        logic [7:0] pats[10];
        pats = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h5A, 8'h0F, 8'hF0, 8'hA5, 8'h3C, 8'hC3};
        write_reg(REG_IMAGE_WIDTH, 16'd40);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        foreach (pats[i]) send_pixel(pats[i]);
    endtask

    // zero width and zero height clamp to a single one-byte row, then width one
    task automatic test_minimum_image();
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        send_pixel(8'h96);
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        send_pixel(8'h69);
    endtask

    // width shrinks mid-row, the next word is past the clip and ends the image
    task automatic test_row_shrink_drop();
        write_reg(REG_IMAGE_WIDTH, 16'd80);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        repeat (6) send_pixel(8'($urandom));
        write_reg(REG_IMAGE_WIDTH, 16'd40);
        send_pixel(8'($urandom));
    endtask

    // limit latched at 5 rows from a wide start, then narrow rows cross a chunk
    // and a height cut leaves a header that still reports one row
    task automatic test_latched_chunk_limit();
        write_reg(REG_IMAGE_WIDTH, 16'd384);
        write_reg(REG_IMAGE_HEIGHT, 16'd10);
        send_pixel(8'($urandom));
        write_reg(REG_IMAGE_WIDTH, 16'd8);
        repeat (5) send_pixel(8'($urandom));
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        send_pixel(8'($urandom));
    endtask

    // widest and tallest settings, upper width bits dropped on write
    task automatic test_extreme_sizes();
        write_reg(REG_IMAGE_WIDTH, 16'd8192);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_pixel(8'($urandom));
        write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
        send_pixel(8'($urandom));
        write_reg(REG_IMAGE_WIDTH, 16'h4008);
        write_reg(REG_IMAGE_HEIGHT, 16'd1);
        send_pixel(8'($urandom));
    endtask

    // random images, some cut short so the next setting lands mid-image
    task automatic test_random_images();
        int unsigned sent, rb, h_eff, n;
        logic [15:0] w_data, h_data;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: w_data = 16'($urandom_range(1, 64));
                5:             w_data = 16'($urandom_range(377, 400));
                6, 7:          w_data = 16'($urandom_range(65, 200));
                8:             w_data = 16'd0;
                default:       w_data = {2'($urandom_range(1, 3)), 14'($urandom_range(1, 24))};
            endcase
            rb = row_len(w_data[WIDTH_W-1:0]);
            if ($urandom_range(0, 5) == 0) h_data = 16'd0;
            else h_data = 16'($urandom_range(1, (rb > 16) ? 2 : 6));
            h_eff = (h_data == 0) ? 1 : h_data;
            n = rb * h_eff;
            if ($urandom_range(0, 6) == 0) n = $urandom_range(1, n);
            case ($urandom_range(0, 3))
                0:       gap_pct = 0;
                1:       gap_pct = 5;
                2:       gap_pct = 15;
                default: gap_pct = 30;
            endcase
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 5;
                2:       stall_pct = 15;
                default: stall_pct = 30;
            endcase
            write_reg(REG_IMAGE_WIDTH, w_data);
            write_reg(REG_IMAGE_HEIGHT, h_data);
            repeat (n) send_pixel(8'($urandom));
            sent += n;
        end
    endtask

    // back-to-back traffic with no gaps and no backpressure
    task automatic test_full_rate_tail();
        int unsigned w;
        gap_pct = 0;
        stall_pct = 0;
        w = $urandom_range(1, 64);
        write_reg(REG_IMAGE_WIDTH, 16'(w));
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        repeat (row_len(14'(w)) * 3) send_pixel(8'($urandom));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_pixel_extremes();
        test_minimum_image();
        test_row_shrink_drop();
        test_latched_chunk_limit();
        test_extreme_sizes();
        gap_pct = 10;
        stall_pct = 10;
        test_random_images();
        test_full_rate_tail();

        // drain and watch for stray bytes
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d pixel words, checked %0d printer bytes, %0d register writes",
                 pixel_words_in, printer_bytes_out, config_writes);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
